>>> rtl/pcrel_pkg.sv
// shared types, encodings and constants of the pc-relative instruction relocator
// used by pcrel_front, pcrel_queue, pcrel_back and the top level; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcrel_pkg;

  // instruction classes as they appear on the result channel
  typedef enum logic [2:0] {
    ClsCopy  = 3'd0,
    ClsB     = 3'd1,
    ClsBcond = 3'd2,
    ClsCbz   = 3'd3,
    ClsTbz   = 3'd4,
    ClsAdr   = 3'd5,
    ClsAdrp  = 3'd6,
    ClsLdrLit = 3'd7
  } cls_e;

  // fixed instruction words of the replacement sequences
  localparam logic [31:0] WordLdrX16  = 32'h5800_0050;  // ldr x16, #8
  localparam logic [31:0] WordBlrX16  = 32'hD63F_0200;  // blr x16
  localparam logic [31:0] WordBrX16   = 32'hD61F_0200;  // br x16
  localparam logic [31:0] WordBcond   = 32'h5400_0000;  // b.cond base
  localparam logic [31:0] WordLdrRd8  = 32'h5800_0040;  // ldr rd, #8 base
  localparam logic [31:0] WordBSkip   = 32'h1400_0003;  // b #0xc
  localparam logic [31:0] WordLdrXRt  = 32'hF940_0000;  // ldr xt, [xn]
  localparam logic [31:0] WordLdrWRt  = 32'hB940_0000;  // ldr wt, [xn]
  localparam logic [31:0] SkipImm     = 32'h0000_00A0;  // branch offset +0x14

  // decode masks and match values
  localparam logic [31:0] MaskB       = 32'h7C00_0000;
  localparam logic [31:0] MatchB      = 32'h1400_0000;
  localparam logic [31:0] MaskBcond   = 32'hFF00_0010;
  localparam logic [31:0] MatchBcond  = 32'h5400_0000;
  localparam logic [31:0] MaskCmpBr   = 32'h7E00_0000;
  localparam logic [31:0] MatchCbz    = 32'h3400_0000;
  localparam logic [31:0] MatchTbz    = 32'h3600_0000;
  localparam logic [31:0] MaskAdr     = 32'h9F00_0000;
  localparam logic [31:0] MatchAdr    = 32'h1000_0000;
  localparam logic [31:0] MatchAdrp   = 32'h9000_0000;
  localparam logic [31:0] MaskLdrLit  = 32'h3B00_0000;
  localparam logic [31:0] MatchLdrLit = 32'h1800_0000;

  // sense flip and keep masks for compare and test branches
  localparam logic [31:0] SenseBit    = 32'h0100_0000;
  localparam logic [31:0] KeepCbz     = 32'hFF00_001F;
  localparam logic [31:0] KeepTbz     = 32'hFFF8_001F;

  // queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // decoded request handed from front to back
  typedef struct packed {
    logic [31:0] word;
    logic [63:0] target;
    cls_e        cls;
    logic        eog;
  } entry_t;

  // number of output words per class, minus one
  function automatic logic [2:0] last_index(input cls_e cls);
    logic [2:0] n;
    unique case (cls)
      ClsCopy:                      n = 3'd0;
      ClsB, ClsAdr, ClsAdrp:        n = 3'd3;
      ClsBcond, ClsCbz, ClsTbz,
      ClsLdrLit:                    n = 3'd4;
      default:                      n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/pcrel_front.sv
// front end: classifies an instruction and computes its absolute target
// depends on pcrel_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrel_front (
  input  wire logic [31:0]       word_i,
  input  wire logic [63:0]       pc_i,
  input  wire logic              eog_i,
  output pcrel_pkg::entry_t      entry_o
);

  pcrel_pkg::cls_e cls;
  logic [63:0]     base;
  logic [63:0]     offset;

  // sign-extended immediates of the pc-relative forms
  logic [63:0] off_b;
  logic [63:0] off_imm19;
  logic [63:0] off_tbz;
  logic [63:0] off_adr;
  logic [63:0] off_adrp;

  assign off_b     = {{36{word_i[25]}}, word_i[25:0], 2'b00};
  assign off_imm19 = {{43{word_i[23]}}, word_i[23:5], 2'b00};
  assign off_tbz   = {{48{word_i[18]}}, word_i[18:5], 2'b00};
  assign off_adr   = {{43{word_i[23]}}, word_i[23:5], word_i[30:29]};
  assign off_adrp  = {{31{word_i[23]}}, word_i[23:5], word_i[30:29], 12'h000};

  // classification, first match wins
  always_comb begin
    base   = pc_i;
    offset = '0;
    priority if ((word_i & pcrel_pkg::MaskB) == pcrel_pkg::MatchB) begin
      cls    = pcrel_pkg::ClsB;
      offset = off_b;
    end else if ((word_i & pcrel_pkg::MaskBcond) == pcrel_pkg::MatchBcond) begin
      cls    = pcrel_pkg::ClsBcond;
      offset = off_imm19;
    end else if ((word_i & pcrel_pkg::MaskCmpBr) == pcrel_pkg::MatchCbz) begin
      cls    = pcrel_pkg::ClsCbz;
      offset = off_imm19;
    end else if ((word_i & pcrel_pkg::MaskCmpBr) == pcrel_pkg::MatchTbz) begin
      cls    = pcrel_pkg::ClsTbz;
      offset = off_tbz;
    end else if ((word_i & pcrel_pkg::MaskAdr) == pcrel_pkg::MatchAdr) begin
      cls    = pcrel_pkg::ClsAdr;
      offset = off_adr;
    end else if ((word_i & pcrel_pkg::MaskAdr) == pcrel_pkg::MatchAdrp) begin
      cls    = pcrel_pkg::ClsAdrp;
      base   = {pc_i[63:12], 12'h000};
      offset = off_adrp;
    end else if ((word_i & pcrel_pkg::MaskLdrLit) == pcrel_pkg::MatchLdrLit) begin
      cls    = pcrel_pkg::ClsLdrLit;
      offset = off_imm19;
    end else begin
      cls    = pcrel_pkg::ClsCopy;
    end
  end

  // target wraps modulo 2^64
  assign entry_o.word   = word_i;
  assign entry_o.target = base + offset;
  assign entry_o.cls    = cls;
  assign entry_o.eog    = eog_i;

endmodule

`default_nettype wire

>>> rtl/pcrel_queue.sv
// short fifo of decoded requests between front and back
// depends on pcrel_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrel_queue #(
  parameter int unsigned Depth = pcrel_pkg::QueueDepth
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire pcrel_pkg::entry_t push_entry_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output pcrel_pkg::entry_t      head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  pcrel_pkg::entry_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pcrel_back.sv
// back end: walks the replacement sequence of the head request, one word a cycle while the result stream is ready
// depends on pcrel_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcrel_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              empty_i,
  input  wire pcrel_pkg::entry_t head_i,
  output logic                   pop_o,
  output logic                   valid_o,
  input  wire logic              ready_i,
  output logic [31:0]            word_o,
  output logic                   last_instr_o,
  output logic                   last_group_o,
  output pcrel_pkg::cls_e        cls_o
);

  logic [2:0]  idx_q, idx_d;
  logic        valid_q;
  logic [31:0] word_q;
  logic        last_instr_q;
  logic        last_group_q;
  pcrel_pkg::cls_e cls_q;

  logic        load;
  logic        at_end;
  logic [31:0] word;
  logic [31:0] first_word;
  logic [31:0] lo;
  logic [31:0] hi;
  logic [4:0]  reg_f;

  assign lo    = head_i.target[31:0];
  assign hi    = head_i.target[63:32];
  assign reg_f = head_i.word[4:0];

  // output slot free or being drained, and a request waits
  assign load   = !empty_i && (!valid_q || ready_i);
  assign at_end = (idx_q == pcrel_pkg::last_index(head_i.cls));
  assign pop_o  = load && at_end;

  // inverted skip branch of the conditional forms
  always_comb begin
    unique case (head_i.cls)
      pcrel_pkg::ClsBcond:
        first_word = pcrel_pkg::WordBcond | pcrel_pkg::SkipImm |
                     {28'h0, head_i.word[3:0] ^ 4'h1};
      pcrel_pkg::ClsCbz:
        first_word = ((head_i.word ^ pcrel_pkg::SenseBit) & pcrel_pkg::KeepCbz) |
                     pcrel_pkg::SkipImm;
      default:
        first_word = ((head_i.word ^ pcrel_pkg::SenseBit) & pcrel_pkg::KeepTbz) |
                     pcrel_pkg::SkipImm;
    endcase
  end

  // word of the sequence at the current index
  always_comb begin
    word = head_i.word;
    unique case (head_i.cls)
      pcrel_pkg::ClsCopy: begin
        word = head_i.word;
      end
      pcrel_pkg::ClsB: begin
        unique case (idx_q)
          3'd0:    word = pcrel_pkg::WordLdrX16;
          3'd1:    word = head_i.word[31] ? pcrel_pkg::WordBlrX16 : pcrel_pkg::WordBrX16;
          3'd2:    word = lo;
          default: word = hi;
        endcase
      end
      pcrel_pkg::ClsBcond, pcrel_pkg::ClsCbz, pcrel_pkg::ClsTbz: begin
        unique case (idx_q)
          3'd0:    word = first_word;
          3'd1:    word = pcrel_pkg::WordLdrX16;
          3'd2:    word = pcrel_pkg::WordBrX16;
          3'd3:    word = lo;
          default: word = hi;
        endcase
      end
      default: begin
        // adr, adrp and literal loads
        unique case (idx_q)
          3'd0:    word = pcrel_pkg::WordLdrRd8 | {27'h0, reg_f};
          3'd1:    word = pcrel_pkg::WordBSkip;
          3'd2:    word = lo;
          3'd3:    word = hi;
          default: word = (head_i.word[30] ? pcrel_pkg::WordLdrXRt : pcrel_pkg::WordLdrWRt) |
                          {22'h0, reg_f, reg_f};
        endcase
      end
    endcase
  end

  // sequence index
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = at_end ? 3'd0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 3'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q       <= word;
      last_instr_q <= at_end;
      last_group_q <= at_end && head_i.eog;
      cls_q        <= head_i.cls;
    end
  end

  assign valid_o      = valid_q;
  assign word_o       = word_q;
  assign last_instr_o = last_instr_q;
  assign last_group_o = last_group_q;
  assign cls_o        = cls_q;

endmodule

`default_nettype wire

>>> rtl/aarch64_pcrel_instruction_relocator.sv
// the first word of a request passes through the queue and then the output register of the back end
// throughput: one output word per cycle while the result stream is ready; a request yields 1 to 5 words,
//   set by the length of its replacement sequence on the single-word result channel
// a short queue lets new requests be accepted while the back end is still emitting
// reset: asynchronous active-low, clears the queue, the sequence index and the output valid
// top level; depends on pcrel_pkg, pcrel_front, pcrel_queue and pcrel_back
`timescale 1ns / 1ps
`default_nettype none

module aarch64_pcrel_instruction_relocator #(
  parameter int unsigned QueueDepth = pcrel_pkg::QueueDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,   // [31:0] instruction_word, [95:32] fetch_address
  input  wire logic        s_axis_tlast_i,   // end_of_group
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,   // [31:0] output_word
  output logic             m_axis_tlast_o,   // last_of_group
  output logic [3:0]       m_axis_tuser_o    // [0] last_of_instruction, [3:1] instruction_class
);

  pcrel_pkg::entry_t front_entry;
  pcrel_pkg::entry_t head;
  pcrel_pkg::cls_e   out_cls;
  logic              full;
  logic              empty;
  logic              pop;
  logic              last_instr;

  // decode
  pcrel_front u_front (
    .word_i  (s_axis_tdata_i[31:0]),
    .pc_i    (s_axis_tdata_i[95:32]),
    .eog_i   (s_axis_tlast_i),
    .entry_o (front_entry)
  );

  assign s_axis_tready_o = !full;

  // request queue
  pcrel_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (s_axis_tvalid_i),
    .push_entry_i (front_entry),
    .full_o       (full),
    .pop_i        (pop),
    .empty_o      (empty),
    .head_o       (head)
  );

  // sequence emission
  pcrel_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .head_i       (head),
    .pop_o        (pop),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i),
    .word_o       (m_axis_tdata_o),
    .last_instr_o (last_instr),
    .last_group_o (m_axis_tlast_o),
    .cls_o        (out_cls)
  );

  assign m_axis_tuser_o = {out_cls, last_instr};

endmodule

`default_nettype wire

>>> tb/sv/aarch64_pcrel_instruction_relocator_tb.sv
// self-checking testbench for the pc-relative instruction relocator: directed
// table plus random requests, with random idling on requests and backpressure on results
// depends on pcrel_pkg and aarch64_pcrel_instruction_relocator
`timescale 1ns / 1ps

module aarch64_pcrel_instruction_relocator_tb;

  localparam int unsigned RandomRequests = 236;
  localparam int unsigned StallLimit     = 2000;
  localparam int unsigned PressureCycles = 150;
  localparam int unsigned DrainCycles    = 12;

  // one word on the result stream
  typedef struct packed {
    logic [31:0]     word;
    logic            last_instr;
    logic            last_grp;
    pcrel_pkg::cls_e cls;
  } reloc_word_t;

  // one row of the directed table; n_typed of zero means the predictor supplies the words
  typedef struct packed {
    logic [31:0]      word;
    logic [63:0]      pc;
    logic             eog;
    logic [2:0]       n_typed;
    pcrel_pkg::cls_e  cls;
    logic [4:0][31:0] typed;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;   // [31:0] instruction_word, [95:32] fetch_address
  logic        s_axis_tlast_i = 1'b0; // end_of_group
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // [31:0] output_word
  logic        m_axis_tlast_o;        // last_of_group
  logic [3:0]  m_axis_tuser_o;        // [0] last_of_instruction, [3:1] instruction_class

  reloc_word_t expected_words[$];
  int unsigned error_count = 0;
  int unsigned requests_sent = 0;
  int unsigned words_checked = 0;
  int unsigned quiet_cycles = 0;
  int unsigned class_seen [8];
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  // directed table: extremes, every class, wrap, b.al, and the literal load variants
  stim_row_t directed_rows [24] = '{
    '{32'h0000_0000, 64'h0, 1'b0, 3'd1, pcrel_pkg::ClsCopy,
      {32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0000}},
    '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 3'd1, pcrel_pkg::ClsCopy,
      {32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF}},
    '{32'h1400_0000, 64'h0, 1'b0, 3'd4, pcrel_pkg::ClsB,
      {32'h0, 32'h0, 32'h0, 32'hD61F_0200, 32'h5800_0050}},
    '{32'h5400_0000, 64'h0, 1'b1, 3'd5, pcrel_pkg::ClsBcond,
      {32'h0, 32'h0, 32'hD61F_0200, 32'h5800_0050, 32'h5400_00A1}},
    '{32'h1800_0000, 64'h0, 1'b0, 3'd5, pcrel_pkg::ClsLdrLit,
      {32'hB940_0000, 32'h0, 32'h0, 32'h1400_0003, 32'h5800_0040}},
    '{32'h97FF_FFFF, 64'h0000_0000_0000_1000, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h15FF_FFFF, 64'hFFFF_FFFF_FFFF_FFF0, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h1600_0000, 64'h0, 1'b1, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h5400_000E, 64'h0000_0000_0000_4000, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h54FF_FFEF, 64'h0, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h5400_0010, 64'h0, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'hB400_0000, 64'h8000_0000_0000_0000, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h35FF_FFFF, 64'h0000_0000_0000_0010, 1'b1, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h3600_0000, 64'h0000_0000_0000_1234, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'hB7FF_FFFF, 64'h7FFF_FFFF_FFFF_FFFC, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h1000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h70FF_FFFF, 64'h0, 1'b1, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h9000_0000, 64'h0000_1234_5678_9FFF, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'hF0FF_FFFF, 64'h0000_0000_0000_0FFF, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h58FF_FFFF, 64'h0000_0000_0000_0000, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h1C00_0001, 64'hFFFF_FFFF_FFF0_0000, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'hD800_0010, 64'h0000_00AB_CDEF_0000, 1'b1, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'h9800_0005, 64'h1234_5678_9ABC_DEF0, 1'b0, 3'd0, pcrel_pkg::ClsCopy, '0},
    '{32'hD503_201F, 64'h5555_5555_5555_5555, 1'b1, 3'd0, pcrel_pkg::ClsCopy, '0}
  };

  aarch64_pcrel_instruction_relocator uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // 12 ns clock
  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    error_count++;
  endtask

  // queue the words of one relocated sequence, flags on the final word
  task automatic queue_sequence(input logic [4:0][31:0] seq, input int unsigned n,
                                input pcrel_pkg::cls_e cls, input logic eog);
    reloc_word_t item;
    for (int unsigned k = 0; k < n; k++) begin
      item.word       = seq[k];
      item.last_instr = (k == n - 1);
      item.last_grp   = (k == n - 1) ? eog : 1'b0;
      item.cls        = cls;
      expected_words.push_back(item);
    end
  endtask

  // work out the replacement sequence of one instruction fetched from pc
  task automatic predict_relocation(input logic [31:0] w, input logic [63:0] pc,
                                    input logic eog);
    logic [63:0]      off26, off19, off14, adr_off, target;
    logic [31:0]      rt;
    logic [4:0][31:0] seq;
    int unsigned      n;
    pcrel_pkg::cls_e  cls;
    off26   = {{36{w[25]}}, w[25:0], 2'b00};
    off19   = {{43{w[23]}}, w[23:5], 2'b00};
    off14   = {{48{w[18]}}, w[18:5], 2'b00};
    adr_off = {{43{w[23]}}, w[23:5], w[30:29]};
    rt      = {27'd0, w[4:0]};
    seq     = '0;
    target  = '0;
    n       = 5;
    // conditional forms: inverted skip over an absolute jump through x16
    seq[1]  = pcrel_pkg::WordLdrX16;
    seq[2]  = pcrel_pkg::WordBrX16;
    if ((w & pcrel_pkg::MaskB) == pcrel_pkg::MatchB) begin
      cls    = pcrel_pkg::ClsB;
      target = pc + off26;
      seq[0] = pcrel_pkg::WordLdrX16;
      seq[1] = w[31] ? pcrel_pkg::WordBlrX16 : pcrel_pkg::WordBrX16;
      n      = 4;
    end else if ((w & pcrel_pkg::MaskBcond) == pcrel_pkg::MatchBcond) begin
      cls    = pcrel_pkg::ClsBcond;
      target = pc + off19;
      seq[0] = pcrel_pkg::WordBcond | pcrel_pkg::SkipImm | {28'd0, w[3:0] ^ 4'h1};
    end else if ((w & pcrel_pkg::MaskCmpBr) == pcrel_pkg::MatchCbz) begin
      cls    = pcrel_pkg::ClsCbz;
      target = pc + off19;
      seq[0] = ((w ^ pcrel_pkg::SenseBit) & pcrel_pkg::KeepCbz) | pcrel_pkg::SkipImm;
    end else if ((w & pcrel_pkg::MaskCmpBr) == pcrel_pkg::MatchTbz) begin
      cls    = pcrel_pkg::ClsTbz;
      target = pc + off14;
      seq[0] = ((w ^ pcrel_pkg::SenseBit) & pcrel_pkg::KeepTbz) | pcrel_pkg::SkipImm;
    end else if ((w & pcrel_pkg::MaskAdr) == pcrel_pkg::MatchAdr) begin
      cls    = pcrel_pkg::ClsAdr;
      target = pc + adr_off;
      n      = 4;
    end else if ((w & pcrel_pkg::MaskAdr) == pcrel_pkg::MatchAdrp) begin
      cls    = pcrel_pkg::ClsAdrp;
      target = {pc[63:12], 12'h000} + {adr_off[51:0], 12'h000};
      n      = 4;
    end else if ((w & pcrel_pkg::MaskLdrLit) == pcrel_pkg::MatchLdrLit) begin
      cls    = pcrel_pkg::ClsLdrLit;
      target = pc + off19;
      seq[4] = (w[30] ? pcrel_pkg::WordLdrXRt : pcrel_pkg::WordLdrWRt) | rt | (rt << 5);
    end else begin
      cls    = pcrel_pkg::ClsCopy;
      n      = 1;
    end
    // literal loaders: ldr rd,#8 ; b #0xc ; literal
    if (cls == pcrel_pkg::ClsAdr || cls == pcrel_pkg::ClsAdrp ||
        cls == pcrel_pkg::ClsLdrLit) begin
      seq[0] = pcrel_pkg::WordLdrRd8 | rt;
      seq[1] = pcrel_pkg::WordBSkip;
    end
    if (cls == pcrel_pkg::ClsB || cls == pcrel_pkg::ClsAdr ||
        cls == pcrel_pkg::ClsAdrp || cls == pcrel_pkg::ClsLdrLit) begin
      seq[2] = target[31:0];
      seq[3] = target[63:32];
    end else if (cls != pcrel_pkg::ClsCopy) begin
      seq[3] = target[31:0];
      seq[4] = target[63:32];
    end else begin
      seq[0] = w;
    end
    queue_sequence(seq, n, cls, eog);
  endtask

  // offer one request after a random gap in idle phases and wait until it is taken
  task automatic send_request(input logic [31:0] w, input logic [63:0] pc, input logic eog);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {pc, w};
    s_axis_tlast_i  <= eog;
    do @(posedge clk_i); while (!s_axis_tready_o);
    requests_sent++;
  endtask

  // reset, directed table, random requests, drain and verdict
  initial begin : stimulus
    logic [31:0]     w;
    logic [63:0]     pc;
    logic            eog;
    pcrel_pkg::cls_e kind;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].word, directed_rows[i].pc, directed_rows[i].eog);
      if (directed_rows[i].n_typed != 0)
        queue_sequence(directed_rows[i].typed, 32'(directed_rows[i].n_typed),
                       directed_rows[i].cls, directed_rows[i].eog);
      else
        predict_relocation(directed_rows[i].word, directed_rows[i].pc, directed_rows[i].eog);
    end

    // random instructions forced into each class, random fields kept
    for (int unsigned i = 0; i < RandomRequests; i++) begin
      if (i % 30 == 0) tx_idle = ($urandom_range(0, 2) != 0);
      kind = pcrel_pkg::cls_e'($urandom_range(0, 7));
      w    = $urandom;
      case (kind)
        pcrel_pkg::ClsB:
          w = (w & ~pcrel_pkg::MaskB) | pcrel_pkg::MatchB;
        pcrel_pkg::ClsBcond:
          w = (w & ~pcrel_pkg::MaskBcond) | pcrel_pkg::MatchBcond;
        pcrel_pkg::ClsCbz:
          w = (w & ~pcrel_pkg::MaskCmpBr) | pcrel_pkg::MatchCbz;
        pcrel_pkg::ClsTbz:
          w = (w & ~pcrel_pkg::MaskCmpBr) | pcrel_pkg::MatchTbz;
        pcrel_pkg::ClsAdr:
          w = (w & ~pcrel_pkg::MaskAdr) | pcrel_pkg::MatchAdr;
        pcrel_pkg::ClsAdrp:
          w = (w & ~pcrel_pkg::MaskAdr) | pcrel_pkg::MatchAdrp;
        pcrel_pkg::ClsLdrLit:
          w = (w & ~pcrel_pkg::MaskLdrLit) | pcrel_pkg::MatchLdrLit;
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0:       pc = {$urandom, $urandom};
        1:       pc = {32'd0, 16'd0, 16'($urandom)};
        default: pc = ~{32'd0, 16'd0, 16'($urandom)};
      endcase
      eog = ($urandom_range(0, 3) == 0);
      send_request(w, pc, eog);
      predict_relocation(w, pc, eog);
    end
    s_axis_tvalid_i <= 1'b0;

    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests, %0d result words, with idling and long output stalls",
             requests_sent, words_checked);
    $display({"sequences per class copy/b/bcond/cbz/tbz/adr/adrp/ldr: ",
              "%0d %0d %0d %0d %0d %0d %0d %0d"},
             class_seen[0], class_seen[1], class_seen[2], class_seen[3],
             class_seen[4], class_seen[5], class_seen[6], class_seen[7]);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // result side: random ready gaps, two long hold-offs to fill the block
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (taken % 40 == 0) rx_idle = ($urandom_range(0, 2) != 0);
      gap = rx_idle ? $urandom_range(0, 6) : 0;
      if (taken == 80 || taken == 500) gap = PressureCycles;
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    reloc_word_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", m_axis_tdata_o));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (m_axis_tdata_o !== want.word)
          report_mismatch($sformatf("word %h, expected %h", m_axis_tdata_o, want.word));
        if (m_axis_tuser_o[0] !== want.last_instr)
          report_mismatch($sformatf("last_of_instruction %b, expected %b on word %h",
                                    m_axis_tuser_o[0], want.last_instr, want.word));
        if (m_axis_tlast_o !== want.last_grp)
          report_mismatch($sformatf("last_of_group %b, expected %b on word %h",
                                    m_axis_tlast_o, want.last_grp, want.word));
        if (m_axis_tuser_o[3:1] !== want.cls)
          report_mismatch($sformatf("class %0d, expected %0d on word %h",
                                    m_axis_tuser_o[3:1], want.cls, want.word));
        if (want.last_instr) class_seen[want.cls]++;
      end
    end
  end

  // count cycles without any handshake on either stream
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("timeout: no request or result moved for %0d cycles", StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
